/* hdl/rpfg_pkg.sv */
// Shared types, codes and constants for the RC pulse failsafe gate.
// No dependencies; every other file in hdl/ imports this package.
`timescale 1ns / 1ps

package rpfg_pkg;

    // Timing constants, microseconds
    localparam logic [31:0] TIMEOUT_US       = 32'd100000;
    localparam logic [11:0] ARM_TOP_US       = 12'd1710;
    localparam logic [11:0] ARM_BOTTOM_US    = 12'd1204;
    localparam logic [11:0] ARM_TOLERANCE_US = 12'd50;

    // Item command codes
    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_POLL = 1'b1;

    // Channel codes
    localparam logic [1:0] CH_MOTOR = 2'd0;
    localparam logic [1:0] CH_STEER = 2'd1;
    localparam logic [1:0] CH_ARM   = 2'd2;
    localparam int unsigned NUM_CH  = 3;

    // Register indexes
    localparam int unsigned NUM_REGS = 8;
    localparam int unsigned REG_IDX_W = $clog2(NUM_REGS);
    localparam int unsigned PADDR_W   = REG_IDX_W + 2;

    localparam logic [REG_IDX_W-1:0] REG_MOTOR_LO  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MOTOR_HI  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_STEER_LO  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_STEER_HI  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ARM_LO    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ARM_HI    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_MOTOR_NTR = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_STEER_NTR = 3'd7;

    // Register reset values
    localparam logic [11:0] RST_MOTOR_LO  = 12'd976;
    localparam logic [11:0] RST_MOTOR_HI  = 12'd2415;
    localparam logic [11:0] RST_STEER_LO  = 12'd742;
    localparam logic [11:0] RST_STEER_HI  = 12'd2266;
    localparam logic [11:0] RST_ARM_LO    = 12'd963;
    localparam logic [11:0] RST_ARM_HI    = 12'd2052;
    localparam logic [11:0] RST_MOTOR_NTR = 12'd1528;
    localparam logic [11:0] RST_STEER_NTR = 12'd1376;

    // State reset values
    localparam logic [11:0] RST_ARM_WIDTH = 12'd1204;

    typedef struct packed {
        logic [11:0] motor_accept_low;
        logic [11:0] motor_accept_high;
        logic [11:0] steer_accept_low;
        logic [11:0] steer_accept_high;
        logic [11:0] arm_accept_low;
        logic [11:0] arm_accept_high;
        logic [11:0] motor_neutral;
        logic [11:0] steer_neutral;
    } cfg_t;

    typedef struct packed {
        logic        cmd;
        logic [1:0]  channel;
        logic [31:0] now_us;
    } item_t;

    typedef struct packed {
        logic        locked;
        logic [11:0] motor_drive_us;
        logic [11:0] steer_drive_us;
        logic [11:0] motor_width_us;
        logic [11:0] steer_width_us;
        logic [11:0] arm_width_us;
        logic        pulse_accepted;
        logic        signal_lost;
    } result_t;

endpackage

/* hdl/rpfg_cfg_regs.sv */
// APB-style configuration register file for the RC pulse failsafe gate.
// Depends on rpfg_pkg for register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module rpfg_cfg_regs
    import rpfg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;
    logic [11:0]          wval;
    logic [11:0]          rval;

    assign pready = 1'b1;
    assign idx    = paddr[PADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign wval   = pwdata[11:0];
    assign cfg    = cfg_reg;

    // Decode the write beat
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_MOTOR_LO:  cfg_next.motor_accept_low  = wval;
                REG_MOTOR_HI:  cfg_next.motor_accept_high = wval;
                REG_STEER_LO:  cfg_next.steer_accept_low  = wval;
                REG_STEER_HI:  cfg_next.steer_accept_high = wval;
                REG_ARM_LO:    cfg_next.arm_accept_low    = wval;
                REG_ARM_HI:    cfg_next.arm_accept_high   = wval;
                REG_MOTOR_NTR: cfg_next.motor_neutral     = wval;
                REG_STEER_NTR: cfg_next.steer_neutral     = wval;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (idx)
            REG_MOTOR_LO:  rval = cfg_reg.motor_accept_low;
            REG_MOTOR_HI:  rval = cfg_reg.motor_accept_high;
            REG_STEER_LO:  rval = cfg_reg.steer_accept_low;
            REG_STEER_HI:  rval = cfg_reg.steer_accept_high;
            REG_ARM_LO:    rval = cfg_reg.arm_accept_low;
            REG_ARM_HI:    rval = cfg_reg.arm_accept_high;
            REG_MOTOR_NTR: rval = cfg_reg.motor_neutral;
            REG_STEER_NTR: rval = cfg_reg.steer_neutral;
            default:       rval = 12'd0;
        endcase
    end

    assign prdata = {20'd0, rval};

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.motor_accept_low  <= RST_MOTOR_LO;
            cfg_reg.motor_accept_high <= RST_MOTOR_HI;
            cfg_reg.steer_accept_low  <= RST_STEER_LO;
            cfg_reg.steer_accept_high <= RST_STEER_HI;
            cfg_reg.arm_accept_low    <= RST_ARM_LO;
            cfg_reg.arm_accept_high   <= RST_ARM_HI;
            cfg_reg.motor_neutral     <= RST_MOTOR_NTR;
            cfg_reg.steer_neutral     <= RST_STEER_NTR;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* hdl/rpfg_gate_core.sv */
// Gate state and single-pass update logic: loss check, width measure,
// window test, drive gating and arm-button lock. Depends on rpfg_pkg.
`timescale 1ns / 1ps

module rpfg_gate_core
    import rpfg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  item_t   item,
    input  logic    fire,
    output result_t result
);

    logic [31:0] last_reg   [NUM_CH];
    logic [31:0] last_next  [NUM_CH];
    logic        lock_reg, lock_next;
    logic [11:0] mdrv_reg, mdrv_next;
    logic [11:0] sdrv_reg, sdrv_next;
    logic [11:0] mwid_reg, mwid_next;
    logic [11:0] swid_reg, swid_next;
    logic [11:0] awid_reg, awid_next;

    logic [31:0] age [NUM_CH];
    logic        lost;
    logic        is_edge;
    logic [31:0] w;
    logic [11:0] lo, hi;
    logic        in_window;
    logic        accepted;
    logic [11:0] w12;
    logic        near_bottom, near_top;

    // Age of every channel's last edge
    always_comb
    begin
        lost = 1'b0;
        for (int i = 0; i < NUM_CH; i++)
        begin
            age[i] = item.now_us - last_reg[i];
            if (age[i] > TIMEOUT_US)
                lost = 1'b1;
        end
    end

    // Select the width and window of the edge channel
    assign is_edge = (item.cmd == CMD_EDGE) && (item.channel <= CH_ARM);

    always_comb
    begin
        case (item.channel)
            CH_MOTOR:
            begin
                w  = age[0];
                lo = cfg.motor_accept_low;
                hi = cfg.motor_accept_high;
            end
            CH_STEER:
            begin
                w  = age[1];
                lo = cfg.steer_accept_low;
                hi = cfg.steer_accept_high;
            end
            CH_ARM:
            begin
                w  = age[2];
                lo = cfg.arm_accept_low;
                hi = cfg.arm_accept_high;
            end
            default:
            begin
                w  = 32'd0;
                lo = 12'd0;
                hi = 12'd0;
            end
        endcase
    end

    assign in_window = (w > {20'd0, lo}) && (w < {20'd0, hi});
    assign accepted  = is_edge && in_window;
    assign w12       = w[11:0];

    // Button level test: |w - level| < tolerance, kept non-negative
    assign near_bottom = ({1'b0, w12} + {1'b0, ARM_TOLERANCE_US} > {1'b0, ARM_BOTTOM_US})
                      && ({1'b0, w12} < {1'b0, ARM_BOTTOM_US} + {1'b0, ARM_TOLERANCE_US});
    assign near_top    = ({1'b0, w12} + {1'b0, ARM_TOLERANCE_US} > {1'b0, ARM_TOP_US})
                      && ({1'b0, w12} < {1'b0, ARM_TOP_US} + {1'b0, ARM_TOLERANCE_US});

    // Next state for this item
    always_comb
    begin
        lock_next = lock_reg;
        mdrv_next = mdrv_reg;
        sdrv_next = sdrv_reg;
        mwid_next = mwid_reg;
        swid_next = swid_reg;
        awid_next = awid_reg;
        for (int i = 0; i < NUM_CH; i++)
            last_next[i] = last_reg[i];

        // Force neutral on signal loss
        if (lost)
        begin
            lock_next = 1'b1;
            mdrv_next = cfg.motor_neutral;
            sdrv_next = cfg.steer_neutral;
        end

        if (accepted)
        begin
            case (item.channel)
                CH_MOTOR:
                begin
                    mwid_next = w12;
                    if (!lock_next)
                        mdrv_next = w12;
                end
                CH_STEER:
                begin
                    swid_next = w12;
                    if (!lock_next)
                        sdrv_next = w12;
                end
                CH_ARM:
                begin
                    awid_next = w12;
                    if (near_bottom)
                    begin
                        lock_next = 1'b1;
                        mdrv_next = cfg.motor_neutral;
                        sdrv_next = cfg.steer_neutral;
                    end
                    if (near_top)
                        lock_next = 1'b0;
                end
                default:
                begin
                    mwid_next = mwid_reg;
                end
            endcase
        end

        // Stamp the edge even when its width is rejected
        if (is_edge)
        begin
            for (int i = 0; i < NUM_CH; i++)
                if (item.channel == i[1:0])
                    last_next[i] = item.now_us;
        end
    end

    // Result carries the values after the update
    always_comb
    begin
        result.locked         = lock_next;
        result.motor_drive_us = mdrv_next;
        result.steer_drive_us = sdrv_next;
        result.motor_width_us = mwid_next;
        result.steer_width_us = swid_next;
        result.arm_width_us   = awid_next;
        result.pulse_accepted = accepted;
        result.signal_lost    = lost;
    end

    // Advance state when the item leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CH; i++)
                last_reg[i] <= 32'd0;
            lock_reg <= 1'b1;
            mdrv_reg <= RST_MOTOR_NTR;
            sdrv_reg <= RST_STEER_NTR;
            mwid_reg <= RST_MOTOR_NTR;
            swid_reg <= RST_STEER_NTR;
            awid_reg <= RST_ARM_WIDTH;
        end
        else if (fire)
        begin
            for (int i = 0; i < NUM_CH; i++)
                last_reg[i] <= last_next[i];
            lock_reg <= lock_next;
            mdrv_reg <= mdrv_next;
            sdrv_reg <= sdrv_next;
            mwid_reg <= mwid_next;
            swid_reg <= swid_next;
            awid_reg <= awid_next;
        end
    end

endmodule

/* hdl/rc_pulse_failsafe_gate.sv */
// Top level of the RC pulse failsafe gate: input register, gate core,
// result register and configuration port. Depends on rpfg_pkg and submodules.
`timescale 1ns / 1ps

// Each item beat (an edge on motor, steering or arm channel, or a poll) gives
// exactly one result beat, and a new item can be taken every cycle unless a
// stalled result holds an item in the input register. The item sits in an input
// register, the gate core runs the loss check, width window and lock logic in
// one pass and updates its state as the item moves to the result register.
// Throughput is one beat per cycle as long as the result side does not stall; a
// stalled result holds in its register while one more item is taken into the
// input register. The configuration registers are 12 bits wide at byte
// addresses 4*i and should be written only while no item is in flight.
module rc_pulse_failsafe_gate
    import rpfg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  item_t              item,
    output logic               result_valid,
    input  logic               result_stall,
    output result_t            result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_vld_reg, item_vld_next;
    result_t res_reg;
    result_t core_res;
    logic    res_vld_reg, res_vld_next;
    logic    res_free;
    logic    fire;
    logic    take;

    rpfg_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rpfg_gate_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (item_reg),
        .fire   (fire),
        .result (core_res)
    );

    // Handshake: result register frees when empty or taken
    assign res_free   = !res_vld_reg || !result_stall;
    assign fire       = item_vld_reg && res_free;
    assign item_stall = item_vld_reg && !res_free;
    assign take       = item_valid && !item_stall;

    assign item_vld_next = take || (item_vld_reg && !fire);
    assign res_vld_next  = fire || (res_vld_reg && result_stall);

    assign result_valid = res_vld_reg;
    assign result       = res_reg;

    // Hold valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            item_vld_reg <= item_vld_next;
            res_vld_reg  <= res_vld_next;
        end
    end

    // Load payload registers
    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item;
        if (fire)
            res_reg <= core_res;
    end

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for rc_pulse_failsafe_gate: directed table, then random edge streams.
// A behavioral predictor of the gate runs beside the block. Depends on rpfg_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
    import rpfg_pkg::*;

    localparam logic [1:0] CH_UNUSED      = 2'd3;
    localparam int         STALL_LIMIT    = 2000;
    localparam int         HOLD_CYCLES    = 60;
    localparam int         PHASE_ITEMS    = 165;
    localparam int         SETTLE_CYCLES  = 4;
    localparam int         END_CYCLES     = 10;

    typedef struct {
        item_t   beat;
        bit      typed;
        result_t want;
    } probe_row_t;

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    item_t              item;
    logic               result_valid;
    logic               result_stall;
    result_t            result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // Predictor copy of the gate state and registers
    cfg_t               gate_cfg;
    logic [31:0]        edge_stamp [NUM_CH];
    logic               gate_locked;
    logic [11:0]        drive_motor;
    logic [11:0]        drive_steer;
    logic [11:0]        width_motor;
    logic [11:0]        width_steer;
    logic [11:0]        width_arm;

    result_t            gate_outputs_due [$];
    probe_row_t         probe_rows [$];
    int                 fail_count;
    int                 sender_idle_pct;
    int                 receiver_stall_pct;
    bit                 hold_request;

    // Random edge stream: unwrapped microsecond time, next edge per channel
    longint unsigned    stream_us;
    longint unsigned    next_due [NUM_CH];
    bit                 pulse_open [NUM_CH];

    rc_pulse_failsafe_gate dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Lock and load both drives with their neutral widths
    function automatic void lock_to_neutral();
        gate_locked = 1'b1;
        drive_motor = gate_cfg.motor_neutral;
        drive_steer = gate_cfg.steer_neutral;
    endfunction

    function automatic bit near_level(input logic [11:0] w, input logic [11:0] level);
        int d;
        d = int'(w) - int'(level);
        if (d < 0)
        begin
            d = -d;
        end
        return d < int'(ARM_TOLERANCE_US);
    endfunction

    // Advance the predicted gate by one item and return its result beat
    function automatic result_t step_gate(input item_t beat);
        result_t     r;
        logic        lost;
        logic        took;
        logic [31:0] w;
        logic [11:0] lo;
        logic [11:0] hi;
        int          ch;
        lost = 1'b0;
        took = 1'b0;
        for (int i = 0; i < NUM_CH; i++)
        begin
            if (beat.now_us - edge_stamp[i] > TIMEOUT_US)
            begin
                lost = 1'b1;
            end
        end
        if (lost)
        begin
            lock_to_neutral();
        end
        if (beat.cmd == CMD_EDGE && beat.channel != CH_UNUSED)
        begin
            ch = int'(beat.channel);
            w  = beat.now_us - edge_stamp[ch];
            case (beat.channel)
                CH_MOTOR:
                begin
                    lo = gate_cfg.motor_accept_low;
                    hi = gate_cfg.motor_accept_high;
                end
                CH_STEER:
                begin
                    lo = gate_cfg.steer_accept_low;
                    hi = gate_cfg.steer_accept_high;
                end
                default:
                begin
                    lo = gate_cfg.arm_accept_low;
                    hi = gate_cfg.arm_accept_high;
                end
            endcase
            if (w > {20'd0, lo} && w < {20'd0, hi})
            begin
                took = 1'b1;
                case (beat.channel)
                    CH_MOTOR:
                    begin
                        width_motor = w[11:0];
                        if (!gate_locked)
                        begin
                            drive_motor = width_motor;
                        end
                    end
                    CH_STEER:
                    begin
                        width_steer = w[11:0];
                        if (!gate_locked)
                        begin
                            drive_steer = width_steer;
                        end
                    end
                    default:
                    begin
                        // Bottom level locks first, top level unlocks after it
                        width_arm = w[11:0];
                        if (near_level(width_arm, ARM_BOTTOM_US))
                        begin
                            lock_to_neutral();
                        end
                        if (near_level(width_arm, ARM_TOP_US))
                        begin
                            gate_locked = 1'b0;
                        end
                    end
                endcase
            end
            edge_stamp[ch] = beat.now_us;
        end
        r.locked         = gate_locked;
        r.motor_drive_us = drive_motor;
        r.steer_drive_us = drive_steer;
        r.motor_width_us = width_motor;
        r.steer_width_us = width_steer;
        r.arm_width_us   = width_arm;
        r.pulse_accepted = took;
        r.signal_lost    = lost;
        return r;
    endfunction

    function automatic cfg_t reset_cfg();
        cfg_t c;
        c.motor_accept_low  = RST_MOTOR_LO;
        c.motor_accept_high = RST_MOTOR_HI;
        c.steer_accept_low  = RST_STEER_LO;
        c.steer_accept_high = RST_STEER_HI;
        c.arm_accept_low    = RST_ARM_LO;
        c.arm_accept_high   = RST_ARM_HI;
        c.motor_neutral     = RST_MOTOR_NTR;
        c.steer_neutral     = RST_STEER_NTR;
        return c;
    endfunction

    function automatic cfg_t random_cfg();
        cfg_t c;
        c.motor_accept_low  = 12'($urandom_range(600, 1100));
        c.motor_accept_high = 12'($urandom_range(1900, 2500));
        c.steer_accept_low  = 12'($urandom_range(600, 1100));
        c.steer_accept_high = 12'($urandom_range(1900, 2500));
        c.arm_accept_low    = 12'($urandom_range(600, 1100));
        c.arm_accept_high   = 12'($urandom_range(1900, 2500));
        c.motor_neutral     = 12'($urandom_range(0, 4095));
        c.steer_neutral     = 12'($urandom_range(0, 4095));
        return c;
    endfunction

    // Pulse width for the stream: arm button levels, window edges, inside the window or any 12-bit value
    function automatic int pick_width(input logic [1:0] ch);
        int lo;
        int hi;
        int r;
        int w;
        case (ch)
            CH_MOTOR:
            begin
                lo = int'(gate_cfg.motor_accept_low);
                hi = int'(gate_cfg.motor_accept_high);
            end
            CH_STEER:
            begin
                lo = int'(gate_cfg.steer_accept_low);
                hi = int'(gate_cfg.steer_accept_high);
            end
            default:
            begin
                lo = int'(gate_cfg.arm_accept_low);
                hi = int'(gate_cfg.arm_accept_high);
            end
        endcase
        r = int'($urandom_range(0, 99));
        if (ch == CH_ARM && r < 40)
        begin
            w = (r < 20) ? int'(ARM_BOTTOM_US) : int'(ARM_TOP_US);
            w = w + int'($urandom_range(0, 120)) - 60;
        end
        else if (r < 50)
        begin
            case ($urandom_range(0, 3))
                0:       w = lo;
                1:       w = lo + 1;
                2:       w = hi - 1;
                default: w = hi;
            endcase
        end
        else if (r < 85 && hi > lo)
        begin
            w = int'($urandom_range(lo, hi));
        end
        else
        begin
            w = int'($urandom_range(0, 4095));
        end
        if (w < 0)
        begin
            w = 0;
        end
        return w;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 4)
        begin
            return int'($urandom_range(95000, 105000));
        end
        return int'($urandom_range(1500, 18000));
    endfunction

    task automatic start_stream();
        if ($urandom_range(0, 3) == 0)
        begin
            stream_us = 64'hFFFF_0000 + $urandom_range(0, 60000);
        end
        else
        begin
            stream_us = longint'($urandom);
        end
        for (int c = 0; c < NUM_CH; c++)
        begin
            next_due[c]   = stream_us + $urandom_range(100, 3000);
            pulse_open[c] = 1'b0;
        end
    endtask

    // Take the earliest edge of the stream and schedule that channel's next one
    task automatic next_stream_edge(output item_t beat);
        int c;
        c = 0;
        for (int i = 1; i < NUM_CH; i++)
        begin
            if (next_due[i] < next_due[c])
            begin
                c = i;
            end
        end
        stream_us    = next_due[c];
        beat.cmd     = CMD_EDGE;
        beat.channel = 2'(c);
        beat.now_us  = stream_us[31:0];
        if (pulse_open[c])
        begin
            next_due[c] = next_due[c] + pick_gap();
        end
        else
        begin
            next_due[c] = next_due[c] + pick_width(2'(c));
        end
        pulse_open[c] = !pulse_open[c];
    endtask

    // Write one register: setup beat, then access beat
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [11:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {20'($urandom), val};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MOTOR_LO:  gate_cfg.motor_accept_low  = val;
            REG_MOTOR_HI:  gate_cfg.motor_accept_high = val;
            REG_STEER_LO:  gate_cfg.steer_accept_low  = val;
            REG_STEER_HI:  gate_cfg.steer_accept_high = val;
            REG_ARM_LO:    gate_cfg.arm_accept_low    = val;
            REG_ARM_HI:    gate_cfg.arm_accept_high   = val;
            REG_MOTOR_NTR: gate_cfg.motor_neutral     = val;
            default:       gate_cfg.steer_neutral     = val;
        endcase
        @(posedge clk);
    endtask

    task automatic write_config(input cfg_t c);
        write_reg(REG_MOTOR_LO,  c.motor_accept_low);
        write_reg(REG_MOTOR_HI,  c.motor_accept_high);
        write_reg(REG_STEER_LO,  c.steer_accept_low);
        write_reg(REG_STEER_HI,  c.steer_accept_high);
        write_reg(REG_ARM_LO,    c.arm_accept_low);
        write_reg(REG_ARM_HI,    c.arm_accept_high);
        write_reg(REG_MOTOR_NTR, c.motor_neutral);
        write_reg(REG_STEER_NTR, c.steer_neutral);
    endtask

    // Offer one item beat, hold it until taken, then queue its result
    task automatic send_beat(input item_t beat, input bit typed, input result_t want);
        result_t due;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= beat;
        do @(posedge clk); while (item_stall);
        due = step_gate(beat);
        gate_outputs_due.push_back(typed ? want : due);
    endtask

    // Drop valid and let every result drain before touching the registers
    task automatic drain();
        item_valid <= 1'b0;
        while (gate_outputs_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic add_row(input logic cmd, input logic [1:0] ch, input logic [31:0] now,
                           input bit typed, input result_t want);
        probe_row_t row;
        row.beat.cmd     = cmd;
        row.beat.channel = ch;
        row.beat.now_us  = now;
        row.typed        = typed;
        row.want         = want;
        probe_rows.push_back(row);
    endtask

    task automatic run_random(input int count, input bit with_hold);
        item_t beat;
        int    r;
        for (int k = 0; k < count; k++)
        begin
            if (with_hold && k == 40)
            begin
                hold_request = 1'b1;
            end
            r = int'($urandom_range(0, 99));
            if (r < 78)
            begin
                next_stream_edge(beat);
            end
            else if (r < 90)
            begin
                beat.cmd     = CMD_POLL;
                beat.channel = 2'($urandom_range(0, 3));
                beat.now_us  = stream_us[31:0] + $urandom_range(0, 3000);
            end
            else
            begin
                beat.cmd     = 1'($urandom_range(0, 1));
                beat.channel = 2'($urandom_range(0, 3));
                if ($urandom_range(0, 1))
                begin
                    beat.now_us = $urandom;
                end
                else
                begin
                    beat.now_us = stream_us[31:0] + $urandom_range(0, 200000);
                end
            end
            send_beat(beat, 1'b0, '0);
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Compare each result beat with the oldest outstanding prediction
    initial
    begin
        result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                if (gate_outputs_due.size() == 0)
                begin
                    $error("result beat with no item outstanding");
                    fail_count++;
                end
                else
                begin
                    want = gate_outputs_due.pop_front();
                    check_field("locked",         want.locked,         result.locked);
                    check_field("motor_drive_us", want.motor_drive_us, result.motor_drive_us);
                    check_field("steer_drive_us", want.steer_drive_us, result.steer_drive_us);
                    check_field("motor_width_us", want.motor_width_us, result.motor_width_us);
                    check_field("steer_width_us", want.steer_width_us, result.steer_width_us);
                    check_field("arm_width_us",   want.arm_width_us,   result.arm_width_us);
                    check_field("pulse_accepted", want.pulse_accepted, result.pulse_accepted);
                    check_field("signal_lost",    want.signal_lost,    result.signal_lost);
                end
            end
        end
    end

    // Result side: random stall, or one long hold-off on request
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_stall <= 1'b1;
                for (int k = 0; k < HOLD_CYCLES; k++)
                begin
                    @(posedge clk);
                end
                result_stall <= 1'b0;
            end
            else
            begin
                result_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
            end
        end
    end

    // End the run when nothing moves for too long
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if ((item_valid && !item_stall) || (result_valid && !result_stall)
                    || (psel && penable))
                begin
                    quiet = 0;
                end
                else
                begin
                    quiet++;
                end
                if (quiet >= STALL_LIMIT)
                begin
                    $display("FAIL rc_pulse_failsafe_gate");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        result_t at_reset;
        result_t at_loss;
        cfg_t    wide;
        cfg_t    closed;

        rst_n              = 1'b0;
        item_valid         = 1'b0;
        item               = '0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        fail_count         = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_request       = 1'b0;

        // Predictor starts from the reset state
        gate_cfg    = reset_cfg();
        for (int i = 0; i < NUM_CH; i++)
        begin
            edge_stamp[i] = '0;
        end
        gate_locked = 1'b1;
        drive_motor = RST_MOTOR_NTR;
        drive_steer = RST_STEER_NTR;
        width_motor = RST_MOTOR_NTR;
        width_steer = RST_STEER_NTR;
        width_arm   = RST_ARM_WIDTH;

        at_reset.locked         = 1'b1;
        at_reset.motor_drive_us = RST_MOTOR_NTR;
        at_reset.steer_drive_us = RST_STEER_NTR;
        at_reset.motor_width_us = RST_MOTOR_NTR;
        at_reset.steer_width_us = RST_STEER_NTR;
        at_reset.arm_width_us   = RST_ARM_WIDTH;
        at_reset.pulse_accepted = 1'b0;
        at_reset.signal_lost    = 1'b0;
        at_loss                 = at_reset;
        at_loss.signal_lost     = 1'b1;

        wide   = {12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095};
        closed = {12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0};

        // Polls at the timeout boundary, unused channel, window edges, arm levels, wrap
        add_row(CMD_POLL, CH_MOTOR,  32'd0,          1'b1, at_reset);
        add_row(CMD_POLL, CH_STEER,  32'd100000,     1'b1, at_reset);
        add_row(CMD_POLL, CH_ARM,    32'd100001,     1'b1, at_loss);
        add_row(CMD_EDGE, CH_UNUSED, 32'd50,         1'b1, at_reset);
        add_row(CMD_EDGE, CH_MOTOR,  32'd976,        1'b0, '0);
        add_row(CMD_EDGE, CH_STEER,  32'd977,        1'b0, '0);
        add_row(CMD_EDGE, CH_ARM,    32'd1204,       1'b0, '0);
        add_row(CMD_EDGE, CH_MOTOR,  32'd1953,       1'b0, '0);
        add_row(CMD_EDGE, CH_ARM,    32'd2914,       1'b0, '0);
        add_row(CMD_EDGE, CH_MOTOR,  32'd4368,       1'b0, '0);
        add_row(CMD_EDGE, CH_STEER,  32'd5000,       1'b0, '0);
        add_row(CMD_EDGE, CH_MOTOR,  32'd6782,       1'b0, '0);
        add_row(CMD_EDGE, CH_STEER,  32'd7000,       1'b0, '0);
        add_row(CMD_EDGE, CH_ARM,    32'd8204,       1'b0, '0);
        add_row(CMD_EDGE, CH_ARM,    32'd9384,       1'b0, '0);
        add_row(CMD_EDGE, CH_MOTOR,  32'd11000,      1'b0, '0);
        add_row(CMD_EDGE, CH_MOTOR,  32'd12500,      1'b0, '0);
        add_row(CMD_POLL, CH_MOTOR,  32'd109384,     1'b0, '0);
        add_row(CMD_EDGE, CH_STEER,  32'hFFFF_FC00,  1'b0, '0);
        add_row(CMD_EDGE, CH_MOTOR,  32'hFFFF_FC10,  1'b0, '0);
        add_row(CMD_EDGE, CH_ARM,    32'hFFFF_FC20,  1'b0, '0);
        add_row(CMD_POLL, CH_ARM,    32'h0000_0010,  1'b0, '0);
        add_row(CMD_EDGE, CH_MOTOR,  32'h0000_0200,  1'b0, '0);
        add_row(CMD_EDGE, CH_STEER,  32'h0000_0300,  1'b0, '0);
        add_row(CMD_POLL, CH_UNUSED, 32'hFFFF_FFFF,  1'b0, '0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probe_rows[i])
        begin
            send_beat(probe_rows[i].beat, probe_rows[i].typed, probe_rows[i].want);
        end

        // Random phases, each with a register setting and an idling mix
        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            case (ph)
                0:       write_config(reset_cfg());
                1:       write_config(wide);
                3:       write_config(closed);
                default: write_config(random_cfg());
            endcase
            case (ph)
                1, 5:
                begin
                    sender_idle_pct    = 66;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 66;
                end
                3:
                begin
                    sender_idle_pct    = 9;
                    receiver_stall_pct = 9;
                end
                default:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
            endcase
            start_stream();
            run_random(PHASE_ITEMS, ph == 4);
        end

        drain();
        repeat (END_CYCLES) @(posedge clk);
        if (fail_count == 0 && gate_outputs_due.size() == 0)
        begin
            $display("PASS rc_pulse_failsafe_gate");
        end
        else
        begin
            $display("FAIL rc_pulse_failsafe_gate");
        end
        $finish;
    end

endmodule
